// File: sv/dct3_pkg.sv
// Shared types and constants for the dominant color finder.
package dct3_pkg;
   localparam int MAX_PIXELS = 4096;
   localparam int NUM_BUCKETS = 64;
   localparam int IDX_W = $clog2(NUM_BUCKETS);
   localparam int CNT_W = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W = CNT_W + 8;
   localparam int ENTRY_W = 3 * SUM_W + CNT_W;
   localparam int QUO_W = 8;
   localparam logic [7:0] DARK_RESET = 8'd20;
   localparam int TOPN = 3;

   typedef struct packed {
      logic acc_en;
      logic clr_en;
      logic [IDX_W-1:0] clr_addr;
      logic scan_rd;
      logic [IDX_W-1:0] scan_addr;
      logic scan_vld;
      logic [1:0] out_rank;
      logic div_start;
      logic emit_none;
      logic emit;
   } dct3_cmd_type;

   typedef struct packed {
      logic div_done;
      logic [1:0] top_n;
   } dct3_sts_type;
endpackage

// File: sv/dct3_ram.sv
// Generic single-port-write, registered-read RAM.
module dct3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_ff;
endmodule

// File: sv/dct3_ctrl.sv
// Controller sequencing accumulation, ranking scan, division and clear.
module dct3_ctrl import dct3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_frame_end,
   output logic         busy,
   output dct3_cmd_type cmd,
   input  dct3_sts_type sts
);
   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001, S_IDLE = 7'b0000010, S_ACC = 7'b0000100,
      S_SCAN = 7'b0001000, S_SEL = 7'b0010000, S_DIV = 7'b0100000,
      S_EMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [IDX_W:0] cnt_ff, cnt_in;
   logic [1:0] rank_ff, rank_in;
   logic fe_ff, fe_in;
   logic vld_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rank_in = rank_ff;
      fe_in = fe_ff;
      cmd = '0;
      cmd.clr_addr = cnt_ff[IDX_W-1:0];
      cmd.scan_addr = cnt_ff[IDX_W-1:0];
      cmd.out_rank = rank_ff;
      cmd.scan_vld = vld_ff;
      busy = 1'b1;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_en = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (IDX_W+1)'(NUM_BUCKETS - 1)) begin
               cnt_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               fe_in = req_frame_end;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            cmd.acc_en = 1'b1;
            cnt_in = '0;
            rank_in = '0;
            state_in = fe_ff ? S_SCAN : S_IDLE;
         end
         S_SCAN: begin
            if (cnt_ff != (IDX_W+1)'(NUM_BUCKETS)) begin
               cmd.scan_rd = 1'b1;
               cnt_in = cnt_ff + 1'b1;
            end else if (!vld_ff) begin
               cnt_in = '0;
               if (sts.top_n == 2'd0) begin
                  cmd.emit_none = 1'b1;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_SEL;
               end
            end
         end
         S_SEL: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_start = (cnt_ff == '0);
            cnt_in = (IDX_W+1)'(1);
            if (sts.div_done && cnt_ff != '0) state_in = S_EMIT;
         end
         S_EMIT: begin
            cmd.emit = 1'b1;
            cnt_in = '0;
            rank_in = rank_ff + 1'b1;
            state_in = (rank_ff + 1'b1 == sts.top_n) ? S_CLEAR : S_SEL;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         cnt_ff <= '0;
         rank_ff <= '0;
         fe_ff <= 1'b0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rank_ff <= rank_in;
         fe_ff <= fe_in;
         vld_ff <= cmd.scan_rd;
      end
   end
endmodule

// File: sv/dct3_path.sv
// Datapath: bucket store, top-three tracker and serial divider.
module dct3_path import dct3_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  logic [7:0]   req_red,
   input  logic [7:0]   req_green,
   input  logic [7:0]   req_blue,
   input  logic         csr_we,
   input  logic [7:0]   csr_wdata,
   input  dct3_cmd_type cmd,
   output dct3_sts_type sts,
   output logic         rsp_valid,
   output logic [7:0]   rsp_red_avg,
   output logic [7:0]   rsp_green_avg,
   output logic [7:0]   rsp_blue_avg,
   output logic [1:0]   rsp_rank,
   output logic         rsp_found,
   output logic         rsp_last_color
);
   logic [7:0] thr_ff;
   logic [7:0] r_ff, g_ff, b_ff;
   logic [7:0] mx;
   logic [IDX_W-1:0] idx;
   logic pass_ff;
   logic [IDX_W-1:0] wa, ra, scan_idx_ff;
   logic [ENTRY_W-1:0] wd, rd;
   logic we;
   logic [SUM_W-1:0] rs, gs, bs;
   logic [CNT_W-1:0] cn;
   logic [IDX_W-1:0] top_ff [TOPN];
   logic [CNT_W-1:0] topc_ff [TOPN];
   logic [1:0] n_ff;
   logic [SUM_W-1:0] rem_ff [3];
   logic [SUM_W-1:0] num_ff [3];
   logic [QUO_W-1:0] q_ff [3];
   logic [CNT_W-1:0] den_ff;
   logic [$clog2(SUM_W+1)-1:0] step_ff;
   logic run_ff;
   logic [CNT_W-1:0] cmp_c;
   logic emit_vld_ff;

   assign mx = (req_red > req_green) ? ((req_red > req_blue) ? req_red : req_blue)
                                     : ((req_green > req_blue) ? req_green : req_blue);
   assign idx = {r_ff[7:6], g_ff[7:6], b_ff[7:6]};
   assign {rs, gs, bs, cn} = rd;
   assign ra = cmd.scan_rd ? cmd.scan_addr : (start && !busy) ?
               {req_red[7:6], req_green[7:6], req_blue[7:6]} : top_ff[cmd.out_rank];
   assign we = cmd.clr_en || (cmd.acc_en && pass_ff && cn != CNT_W'(MAX_PIXELS));
   assign wa = cmd.clr_en ? cmd.clr_addr : idx;
   assign wd = cmd.clr_en ? '0 : {rs + SUM_W'(r_ff), gs + SUM_W'(g_ff),
                                  bs + SUM_W'(b_ff), cn + 1'b1};

   dct3_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_BUCKETS)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd),
      .rd_addr(ra), .rd_data(rd));

   assign sts.top_n = n_ff;
   assign sts.div_done = run_ff && step_ff == '0;
   assign cmp_c = cn;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= DARK_RESET;
      else if (csr_we) thr_ff <= csr_wdata;
      if (start && !busy) begin
         r_ff <= req_red;
         g_ff <= req_green;
         b_ff <= req_blue;
         pass_ff <= mx >= thr_ff;
      end
      scan_idx_ff <= cmd.scan_addr;
      if (cmd.acc_en) begin
         n_ff <= '0;
         for (int k = 0; k < TOPN; k++) topc_ff[k] <= '0;
      end else if (cmd.scan_vld && cmp_c != '0) begin
         if (cmp_c > topc_ff[0]) begin
            top_ff[2] <= top_ff[1]; topc_ff[2] <= topc_ff[1];
            top_ff[1] <= top_ff[0]; topc_ff[1] <= topc_ff[0];
            top_ff[0] <= scan_idx_ff; topc_ff[0] <= cmp_c;
            if (n_ff != 2'd3) n_ff <= n_ff + 1'b1;
         end else if (cmp_c > topc_ff[1]) begin
            top_ff[2] <= top_ff[1]; topc_ff[2] <= topc_ff[1];
            top_ff[1] <= scan_idx_ff; topc_ff[1] <= cmp_c;
            if (n_ff != 2'd3) n_ff <= n_ff + 1'b1;
         end else if (cmp_c > topc_ff[2]) begin
            top_ff[2] <= scan_idx_ff; topc_ff[2] <= cmp_c;
            if (n_ff != 2'd3) n_ff <= n_ff + 1'b1;
         end
      end
      if (reset) run_ff <= 1'b0;
      else if (cmd.div_start) begin
         num_ff[0] <= rs; num_ff[1] <= gs; num_ff[2] <= bs;
         den_ff <= cn;
         for (int k = 0; k < 3; k++) begin
            rem_ff[k] <= '0;
            q_ff[k] <= '0;
         end
         step_ff <= $bits(step_ff)'(SUM_W);
         run_ff <= 1'b1;
      end else if (run_ff && step_ff != '0) begin
         for (int k = 0; k < 3; k++) begin
            logic [SUM_W:0] t;
            t = {rem_ff[k], num_ff[k][SUM_W-1]};
            num_ff[k] <= num_ff[k] << 1;
            if (t >= (SUM_W+1)'(den_ff)) begin
               rem_ff[k] <= SUM_W'(t - (SUM_W+1)'(den_ff));
               q_ff[k] <= {q_ff[k][QUO_W-2:0], 1'b1};
            end else begin
               rem_ff[k] <= t[SUM_W-1:0];
               q_ff[k] <= {q_ff[k][QUO_W-2:0], 1'b0};
            end
         end
         step_ff <= step_ff - 1'b1;
      end else if (cmd.emit) run_ff <= 1'b0;
      if (reset) emit_vld_ff <= 1'b0;
      else emit_vld_ff <= cmd.emit || cmd.emit_none;
      rsp_red_avg <= cmd.emit ? q_ff[0] : '0;
      rsp_green_avg <= cmd.emit ? q_ff[1] : '0;
      rsp_blue_avg <= cmd.emit ? q_ff[2] : '0;
      rsp_rank <= cmd.emit ? cmd.out_rank : '0;
      rsp_found <= cmd.emit;
      rsp_last_color <= cmd.emit_none || (cmd.out_rank + 1'b1 == n_ff);
   end
   assign rsp_valid = emit_vld_ff;
endmodule

// File: sv/dominant_color_top3.sv
// Top level of the three-color dominant color finder.
// Usage: drive req_red/green/blue and req_frame_end with start high while busy
// is low; the request is taken at that edge. Each pixel at or above the dark
// threshold adds to one of 64 color buckets held in a block RAM.
// A pixel is handled as a RAM read, then a read-modify-write; busy is high
// during the write, so a new request is taken only after it is done.
// On frame end the block scans the 64 buckets, then per chosen color
// selects the bucket, runs a serial divider of SUM_W steps (21 steps at
// default) and emits one result: rsp_valid is high for one cycle with
// the averages, rank, found and last_color. An empty frame gives one
// result, found low. Afterwards the store is cleared bucket by bucket
// while busy stays high. Reset clears the store the same way and sets
// the threshold to 20. csr_we writes the threshold. The receiver cannot
// stall: each result must be taken in the cycle it is shown.
module dominant_color_top3 import dct3_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic       req_frame_end,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   output logic       rsp_valid,
   output logic [7:0] rsp_red_avg,
   output logic [7:0] rsp_green_avg,
   output logic [7:0] rsp_blue_avg,
   output logic [1:0] rsp_rank,
   output logic       rsp_found,
   output logic       rsp_last_color
);
   dct3_cmd_type cmd;
   dct3_sts_type sts;

   dct3_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .req_frame_end(req_frame_end),
      .busy(busy), .cmd(cmd), .sts(sts));

   dct3_path u_path (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .csr_we(csr_we), .csr_wdata(csr_wdata), .cmd(cmd), .sts(sts),
      .rsp_valid(rsp_valid), .rsp_red_avg(rsp_red_avg),
      .rsp_green_avg(rsp_green_avg), .rsp_blue_avg(rsp_blue_avg),
      .rsp_rank(rsp_rank), .rsp_found(rsp_found),
      .rsp_last_color(rsp_last_color));
endmodule

// File: dv/dominant_color_top3_tb.sv
// Testbench for dominant_color_top3: random and directed frames against a predictor.
module dominant_color_top3_tb import dct3_pkg::*;;

   typedef struct {
      logic [7:0] red_avg;
      logic [7:0] green_avg;
      logic [7:0] blue_avg;
      logic [1:0] rank;
      logic       found;
      logic       last_color;
   } color_type;

   class color_scoreboard;
      logic [7:0]  dark_thr;
      int unsigned red_sum[NUM_BUCKETS];
      int unsigned grn_sum[NUM_BUCKETS];
      int unsigned blu_sum[NUM_BUCKETS];
      int unsigned pix_cnt[NUM_BUCKETS];
      color_type   pending_colors[$];
      int          mismatches;

      function new();
         dark_thr = DARK_RESET;
         mismatches = 0;
         clear_buckets();
      endfunction

      function void clear_buckets();
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            red_sum[i] = 0; grn_sum[i] = 0; blu_sum[i] = 0; pix_cnt[i] = 0;
         end
      endfunction

      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
         logic [7:0] mx;
         int idx;
         int top[3];
         int unsigned topc[3];
         int n;
         color_type c;
         mx = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         if (mx >= dark_thr) begin
            idx = int'({r[7:6], g[7:6], b[7:6]});
            if (pix_cnt[idx] < MAX_PIXELS) begin
               red_sum[idx] += r; grn_sum[idx] += g; blu_sum[idx] += b;
               pix_cnt[idx] += 1;
            end
         end
         if (!fe) return;
         top = '{-1, -1, -1};
         topc = '{0, 0, 0};
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            if (pix_cnt[i] == 0) continue;
            if (pix_cnt[i] > topc[0]) begin
               top[2] = top[1]; topc[2] = topc[1];
               top[1] = top[0]; topc[1] = topc[0];
               top[0] = i; topc[0] = pix_cnt[i];
            end else if (pix_cnt[i] > topc[1]) begin
               top[2] = top[1]; topc[2] = topc[1];
               top[1] = i; topc[1] = pix_cnt[i];
            end else if (pix_cnt[i] > topc[2]) begin
               top[2] = i; topc[2] = pix_cnt[i];
            end
         end
         n = 0;
         while (n < 3 && top[n] >= 0) n++;
         if (n == 0) begin
            c = '{8'd0, 8'd0, 8'd0, 2'd0, 1'b0, 1'b1};
            pending_colors.push_back(c);
         end
         for (int i = 0; i < n; i++) begin
            c.red_avg = 8'(red_sum[top[i]] / pix_cnt[top[i]]);
            c.green_avg = 8'(grn_sum[top[i]] / pix_cnt[top[i]]);
            c.blue_avg = 8'(blu_sum[top[i]] / pix_cnt[top[i]]);
            c.rank = 2'(i);
            c.found = 1'b1;
            c.last_color = (i == n - 1);
            pending_colors.push_back(c);
         end
         clear_buckets();
      endfunction

      function void check_color(color_type act);
         color_type exp;
         if (pending_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", act);
            return;
         end
         exp = pending_colors.pop_front();
         if (exp != act) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, act);
         end
      endfunction
   endclass

   logic       clock = 0;
   logic       reset = 1;
   logic       start = 0;
   logic       busy;
   logic [7:0] req_red = 0, req_green = 0, req_blue = 0;
   logic       req_frame_end = 0;
   logic       csr_we = 0;
   logic [7:0] csr_wdata = 0;
   logic       rsp_valid;
   logic [7:0] rsp_red_avg, rsp_green_avg, rsp_blue_avg;
   logic [1:0] rsp_rank;
   logic       rsp_found, rsp_last_color;

   color_scoreboard sb = new();
   int idle_cycles = 0;
   localparam int WATCHDOG = 20000;

   dominant_color_top3 dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_color('{rsp_red_avg, rsp_green_avg, rsp_blue_avg, rsp_rank,
                          rsp_found, rsp_last_color});
      if (!reset && ((start && !busy) || rsp_valid)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fe);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         start <= 0;
         repeat (gap) @(negedge clock);
      end
      req_red <= r; req_green <= g; req_blue <= b; req_frame_end <= fe;
      start <= 1;
      do @(posedge clock); while (busy);
      sb.note_pixel(r, g, b, fe);
      @(negedge clock);
   endtask

   task automatic set_threshold(logic [7:0] v);
      start <= 0;
      while (sb.pending_colors.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      while (busy) @(negedge clock);
      csr_wdata <= v;
      csr_we <= 1;
      @(posedge clock);
      sb.dark_thr = v;
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic random_frame(int len);
      logic [7:0] base[3];
      for (int k = 0; k < 3; k++) base[k] = 8'($urandom_range(0, 255));
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 2) == 0)
            send_pixel(base[0] ^ 8'($urandom_range(0, 15)),
                       base[1] ^ 8'($urandom_range(0, 15)),
                       base[2] ^ 8'($urandom_range(0, 15)), i == len - 1);
         else
            send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), i == len - 1);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // empty frame, then dark and tie cases at default threshold
      send_pixel(8'd0, 8'd0, 8'd19, 1);
      send_pixel(8'd20, 8'd0, 8'd0, 0);
      send_pixel(8'd255, 8'd255, 8'd255, 0);
      send_pixel(8'd0, 8'd255, 8'd0, 0);
      send_pixel(8'd0, 8'd0, 8'd255, 1);
      send_pixel(8'd255, 8'd255, 8'd255, 0);
      send_pixel(8'd200, 8'd250, 8'd240, 0);
      send_pixel(8'd128, 8'd64, 8'd0, 0);
      send_pixel(8'd100, 8'd100, 8'd100, 0);
      send_pixel(8'd99, 8'd101, 8'd127, 0);
      send_pixel(8'd255, 8'd0, 8'd0, 1);
      set_threshold(8'd0);
      send_pixel(8'd0, 8'd0, 8'd0, 0);
      send_pixel(8'd1, 8'd2, 8'd3, 1);
      set_threshold(8'd255);
      send_pixel(8'd254, 8'd254, 8'd254, 0);
      send_pixel(8'd255, 8'd10, 8'd10, 1);
      send_pixel(8'd254, 8'd0, 8'd0, 1);
      set_threshold(8'd20);
      for (int f = 0; f < 10; f++) random_frame($urandom_range(1, 12));
      set_threshold(8'($urandom_range(1, 254)));
      for (int f = 0; f < 4; f++) random_frame($urandom_range(1, 8));
      set_threshold(8'd0);
      for (int f = 0; f < 3; f++) random_frame($urandom_range(1, 6));
      start <= 0;
      while (sb.pending_colors.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (sb.mismatches == 0 && sb.pending_colors.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule

// File: dominant_color_top3.f
sv/dct3_pkg.sv
sv/dct3_ram.sv
sv/dct3_ctrl.sv
sv/dct3_path.sv
sv/dominant_color_top3.sv
dv/dominant_color_top3_tb.sv
